// ===== design/vfs_pkg.sv =====
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared constants, request codes and control/status types of the VGA
// frame buffer scan-out unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vfs_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 120;
  localparam int unsigned SCREEN_HEIGHT_DEF = 60;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned PIX_ADDR_W = 13;
  localparam int unsigned COLOR_W    = 3;
  localparam int unsigned FRAME_W    = 32;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned LINE_W     = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned HSYNC_W  = 6;
  localparam int unsigned LSLOTS_W = 8;
  localparam int unsigned VBLANK_W = 7;
  localparam int unsigned VSYNC_W  = 4;

  localparam logic [HSYNC_W-1:0]  HSYNC_SLOTS_RST  = 6'd4;
  localparam logic [LSLOTS_W-1:0] LINE_SLOTS_RST   = 8'd136;
  localparam logic [VBLANK_W-1:0] VBLANK_LINES_RST = 7'd45;
  localparam logic [VSYNC_W-1:0]  VSYNC_LINES_RST  = 4'd2;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HSYNC_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SLOTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_LINES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VSYNC_LINES  = 2'd3;

  typedef struct packed {
    logic tick_go;
    logic wr_go;
    logic clr_start;
    logic clr_step;
  } vfs_cmd_t;

  typedef struct packed {
    logic clr_last;
  } vfs_sts_t;

endpackage

`default_nettype wire

// ===== design/vfs_store.sv =====
// ----------------------------------------------------------------------------
// vfs_store
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_store
  import vfs_pkg::*;
#(
  parameter int unsigned DEPTH  = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF,
  parameter int unsigned ADDR_W = 13
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [ADDR_W-1:0]  waddr_i,
  input  wire logic [COLOR_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [ADDR_W-1:0]  raddr_i,
  output logic      [COLOR_W-1:0] rdata_o
);

  logic [COLOR_W-1:0] mem_q [DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/vfs_datapath.sv =====
// ----------------------------------------------------------------------------
// vfs_datapath
// Configuration registers, slot/line/frame counters, clear sweep pointer,
// frame store and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_datapath
  import vfs_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vfs_cmd_t              cmd_i,
  output vfs_sts_t                   sts_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [PIX_ADDR_W-1:0] pixel_addr_i,
  input  wire logic [COLOR_W-1:0]    pixel_color_i,
  output logic                       red_o,
  output logic                       green_o,
  output logic                       blue_o,
  output logic                       hsync_n_o,
  output logic                       vsync_n_o,
  output logic [FRAME_W-1:0]         frame_count_o
);

  localparam int unsigned STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned SA_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned ROW_W = $clog2(STORE_SIZE + 1);
  localparam int unsigned SUM_W = ROW_W + SLOT_W + 1;

  localparam logic [SA_W-1:0]    CLR_LAST = SA_W'(STORE_SIZE - 1);
  localparam logic [ROW_W:0]     ROW_STEP = (ROW_W + 1)'(SCREEN_WIDTH);
  localparam logic [SLOT_W:0]    WIDTH_C  = (SLOT_W + 1)'(SCREEN_WIDTH);
  localparam logic [LINE_W:0]    HEIGHT_C = (LINE_W + 1)'(SCREEN_HEIGHT);
  localparam logic [31:0]        SIZE_C   = 32'(STORE_SIZE);

  logic [HSYNC_W-1:0]  hsync_slots_q;
  logic [LSLOTS_W-1:0] line_slots_q;
  logic [VBLANK_W-1:0] vblank_lines_q;
  logic [VSYNC_W-1:0]  vsync_lines_q;

  logic [SLOT_W-1:0]   slot_q,  slot_d;
  logic [LINE_W-1:0]   line_q,  line_d;
  logic [ROW_W-1:0]    row_q,   row_d;
  logic [FRAME_W-1:0]  frames_q, frames_d;

  logic [SA_W-1:0]     clr_ptr_q;
  logic [COLOR_W-1:0]  clr_color_q;

  logic                vis_q, hsync_n_q, vsync_n_q;
  logic [FRAME_W-1:0]  fc_q;

  logic [SLOT_W:0]     slot_nx;
  logic [LINE_W:0]     line_nx;
  logic [LINE_W:0]     line_lim;
  logic [ROW_W:0]      row_nx;
  logic [SLOT_W-1:0]   col;
  logic                vis;
  logic [SUM_W-1:0]    rd_sum;
  logic [31:0]         wr_addr_ext;
  logic                wr_ok;

  logic                st_we;
  logic [SA_W-1:0]     st_waddr;
  logic [COLOR_W-1:0]  st_wdata;
  logic [COLOR_W-1:0]  st_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsync_slots_q  <= HSYNC_SLOTS_RST;
      line_slots_q   <= LINE_SLOTS_RST;
      vblank_lines_q <= VBLANK_LINES_RST;
      vsync_lines_q  <= VSYNC_LINES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HSYNC_SLOTS:  hsync_slots_q  <= cfg_data_i[HSYNC_W-1:0];
        CFG_LINE_SLOTS:   line_slots_q   <= cfg_data_i[LSLOTS_W-1:0];
        CFG_VBLANK_LINES: vblank_lines_q <= cfg_data_i[VBLANK_W-1:0];
        CFG_VSYNC_LINES:  vsync_lines_q  <= cfg_data_i[VSYNC_W-1:0];
        default: ;
      endcase
    end
  end

  // visibility and read address of the current slot
  always_comb begin
    col    = slot_q - SLOT_W'(hsync_slots_q);
    vis    = ({1'b0, line_q} < HEIGHT_C) &&
             (slot_q >= SLOT_W'(hsync_slots_q)) &&
             ({1'b0, col} < WIDTH_C);
    rd_sum = SUM_W'(row_q) + SUM_W'(col);
  end

  // advance position
  always_comb begin
    slot_nx  = {1'b0, slot_q} + 1'b1;
    line_nx  = {1'b0, line_q} + 1'b1;
    line_lim = HEIGHT_C + (LINE_W + 1)'(vblank_lines_q);
    row_nx   = {1'b0, row_q} + ROW_STEP;
    slot_d   = slot_q;
    line_d   = line_q;
    row_d    = row_q;
    frames_d = frames_q;
    if (cmd_i.tick_go) begin
      if (slot_nx >= (SLOT_W + 1)'(line_slots_q)) begin
        slot_d = '0;
        if (line_nx >= line_lim) begin
          line_d   = '0;
          row_d    = '0;
          frames_d = frames_q + 1'b1;
        end else begin
          line_d = line_nx[LINE_W-1:0];
          if ({1'b0, line_q} < HEIGHT_C) begin
            row_d = row_nx[ROW_W-1:0];
          end
        end
      end else begin
        slot_d = slot_nx[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      line_q      <= '0;
      row_q       <= '0;
      frames_q    <= '0;
      clr_ptr_q   <= '0;
      clr_color_q <= '0;
    end else begin
      slot_q   <= slot_d;
      line_q   <= line_d;
      row_q    <= row_d;
      frames_q <= frames_d;
      if (cmd_i.clr_start) begin
        clr_ptr_q   <= '0;
        clr_color_q <= pixel_color_i;
      end else if (cmd_i.clr_step) begin
        clr_ptr_q <= clr_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_go) begin
      vis_q     <= vis;
      hsync_n_q <= (slot_q >= SLOT_W'(hsync_slots_q));
      vsync_n_q <= (line_q >= LINE_W'(vsync_lines_q));
      fc_q      <= frames_q;
    end
  end

  always_comb begin
    wr_addr_ext = 32'(pixel_addr_i);
    wr_ok       = wr_addr_ext < SIZE_C;
    st_we       = cmd_i.clr_step || (cmd_i.wr_go && wr_ok);
    st_waddr    = cmd_i.clr_step ? clr_ptr_q : wr_addr_ext[SA_W-1:0];
    st_wdata    = cmd_i.clr_step ? clr_color_q : pixel_color_i;
  end

  vfs_store #(
    .DEPTH  (STORE_SIZE),
    .ADDR_W (SA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (cmd_i.tick_go),
    .raddr_i (rd_sum[SA_W-1:0]),
    .rdata_o (st_rdata)
  );

  assign sts_o.clr_last = (clr_ptr_q == CLR_LAST);

  assign red_o         = vis_q & st_rdata[2];
  assign green_o       = vis_q & st_rdata[1];
  assign blue_o        = vis_q & st_rdata[0];
  assign hsync_n_o     = hsync_n_q;
  assign vsync_n_o     = vsync_n_q;
  assign frame_count_o = fc_q;

endmodule

`default_nettype wire

// ===== design/vfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfs_ctrl
// Controller: store clearing sweep, item decode and result valid tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module vfs_ctrl
  import vfs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [REQ_W-1:0] req_type_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output vfs_cmd_t              cmd_o,
  input  wire vfs_sts_t         sts_i
);

  typedef enum logic {
    S_CLEAR,
    S_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  always_comb begin
    in_stall_o      = (state_q == S_CLEAR) || (out_valid_q && out_stall_i);
    in_acc          = in_valid_i && !in_stall_o;
    cmd_o           = '0;
    cmd_o.clr_step  = (state_q == S_CLEAR);
    cmd_o.tick_go   = in_acc && (req_type_i == REQ_TICK);
    cmd_o.wr_go     = in_acc && (req_type_i == REQ_WRITE);
    cmd_o.clr_start = in_acc && (req_type_i == REQ_CLEAR);
    out_valid_d     = cmd_o.tick_go || (out_valid_q && out_stall_i);
    state_d         = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd_o.clr_start) begin
          state_d = S_CLEAR;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/vga_framebuffer_scanout_unit.sv =====
// ----------------------------------------------------------------------------
// vga_framebuffer_scanout_unit
// VGA scan-out engine with a 3-bit-per-pixel frame store: pixel ticks give
// sync and colour, write items store a pixel, clear items fill the store.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  req_type, pixel_addr, pixel_color
//   out      output     out_valid/out_stall  red, green, blue, hsync_n,
//                                            vsync_n, frame_count
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A tick's result shows the cycle after it is taken, and a new item is taken
// in the cycle its result leaves.
// A clear item walks the store one pixel a cycle, all SCREEN_WIDTH*SCREEN_HEIGHT
// pixels (7200 by default), with the input stalled.
// After reset the same sweep fills the store with black before the first item.
// A stalled result holds the input stalled; configuration writes are always
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vga_framebuffer_scanout_unit
  import vfs_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [REQ_W-1:0]      req_type_i,
  input  wire logic [PIX_ADDR_W-1:0] pixel_addr_i,
  input  wire logic [COLOR_W-1:0]    pixel_color_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       red_o,
  output logic                       green_o,
  output logic                       blue_o,
  output logic                       hsync_n_o,
  output logic                       vsync_n_o,
  output logic [FRAME_W-1:0]         frame_count_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  vfs_cmd_t cmd;
  vfs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  vfs_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_addr_i  (pixel_addr_i),
    .pixel_color_i (pixel_color_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .hsync_n_o     (hsync_n_o),
    .vsync_n_o     (vsync_n_o),
    .frame_count_o (frame_count_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/vga_framebuffer_scanout_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vga_framebuffer_scanout_unit_tb
// Self-checking testbench of the VGA frame buffer scan-out unit. A table of
// directed items runs first, then random ticks, pixel writes and clears
// under a series of timing register settings. A scan-out model predicts the
// tick results the table does not give; a monitor compares each field.
// ----------------------------------------------------------------------------

module vga_framebuffer_scanout_unit_tb;
  import vfs_pkg::*;

  localparam int unsigned  STORE_SIZE   = SCREEN_WIDTH_DEF * SCREEN_HEIGHT_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned  NUM_PHASES   = 10;
  localparam int unsigned  PHASE_ITEMS  = 125;
  localparam int unsigned  CYCLE_LIMIT  = 1000000;
  localparam int unsigned  MAX_PRINTS   = 100;

  typedef struct packed {
    logic              red;
    logic              green;
    logic              blue;
    logic              hsync_n;
    logic              vsync_n;
    logic [FRAME_W-1:0] frames;
  } pix_t;

  typedef struct {
    logic [REQ_W-1:0]      req;
    logic [PIX_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]    color;
    bit                    typed;
    pix_t                  res;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i;
  logic [PIX_ADDR_W-1:0] pixel_addr_i;
  logic [COLOR_W-1:0]    pixel_color_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  red_o;
  logic                  green_o;
  logic                  blue_o;
  logic                  hsync_n_o;
  logic                  vsync_n_o;
  logic [FRAME_W-1:0]    frame_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [COLOR_W-1:0] shadow_store [0:STORE_SIZE-1];
  int unsigned        shadow_slot;
  int unsigned        shadow_line;
  logic [FRAME_W-1:0] shadow_frames;
  int unsigned        shadow_hsync;
  int unsigned        shadow_line_slots;
  int unsigned        shadow_vblank;
  int unsigned        shadow_vsync;

  pix_t        expected_pixels [$];
  row_t        directed_rows [$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          quiet;
  pix_t        mon_want;
  logic [CFG_DATA_W-1:0] phase_cfg [NUM_PHASES][4];

  vga_framebuffer_scanout_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .pixel_addr_i  (pixel_addr_i),
    .pixel_color_i (pixel_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .hsync_n_o     (hsync_n_o),
    .vsync_n_o     (vsync_n_o),
    .frame_count_o (frame_count_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic pix_t make_pix(input logic r, input logic g, input logic b,
                                    input logic hs, input logic vs,
                                    input logic [FRAME_W-1:0] f);
    pix_t p;
    p.red     = r;
    p.green   = g;
    p.blue    = b;
    p.hsync_n = hs;
    p.vsync_n = vs;
    p.frames  = f;
    return p;
  endfunction

  function automatic void scan_step(input logic [REQ_W-1:0] req,
                                    input logic [PIX_ADDR_W-1:0] addr,
                                    input logic [COLOR_W-1:0] color,
                                    output bit has_res, output pix_t res);
    int unsigned        col;
    bit                 vis;
    logic [COLOR_W-1:0] c;
    has_res = 1'b0;
    res     = '0;
    if (req == REQ_WRITE) begin
      if (addr < STORE_SIZE) shadow_store[addr] = color;
    end else if (req == REQ_CLEAR) begin
      for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = color;
    end else if (req == REQ_TICK) begin
      col = 0;
      vis = shadow_line < SCREEN_HEIGHT_DEF && shadow_slot >= shadow_hsync;
      if (vis) begin
        col = shadow_slot - shadow_hsync;
        vis = col < SCREEN_WIDTH_DEF;
      end
      c = '0;
      if (vis) c = shadow_store[shadow_line * SCREEN_WIDTH_DEF + col];
      has_res = 1'b1;
      res = make_pix(c[2], c[1], c[0], shadow_slot >= shadow_hsync,
                     shadow_line >= shadow_vsync, shadow_frames);
      shadow_slot++;
      if (shadow_slot >= shadow_line_slots) begin
        shadow_slot = 0;
        shadow_line++;
        if (shadow_line >= SCREEN_HEIGHT_DEF + shadow_vblank) begin
          shadow_line   = 0;
          shadow_frames = shadow_frames + 1;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] got,
                                 input logic [FRAME_W-1:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no item pending", frame_count_o, '0);
      end else begin
        mon_want = expected_pixels.pop_front();
        if (red_o !== mon_want.red)
          report_mismatch("red", FRAME_W'(red_o), FRAME_W'(mon_want.red));
        if (green_o !== mon_want.green)
          report_mismatch("green", FRAME_W'(green_o), FRAME_W'(mon_want.green));
        if (blue_o !== mon_want.blue)
          report_mismatch("blue", FRAME_W'(blue_o), FRAME_W'(mon_want.blue));
        if (hsync_n_o !== mon_want.hsync_n)
          report_mismatch("hsync_n", FRAME_W'(hsync_n_o), FRAME_W'(mon_want.hsync_n));
        if (vsync_n_o !== mon_want.vsync_n)
          report_mismatch("vsync_n", FRAME_W'(vsync_n_o), FRAME_W'(mon_want.vsync_n));
        if (frame_count_o !== mon_want.frames)
          report_mismatch("frame_count", frame_count_o, mon_want.frames);
      end
    end
  end

  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [PIX_ADDR_W-1:0] addr,
                           input logic [COLOR_W-1:0] color, input bit typed,
                           input pix_t typed_res);
    bit   has_res;
    pix_t res;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    pixel_addr_i  <= addr;
    pixel_color_i <= color;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    scan_step(req, addr, color, has_res, res);
    if (has_res) expected_pixels.push_back(typed ? typed_res : res);
  endtask

  task automatic hold_input(input int unsigned n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results;
    hold_input(1);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_HSYNC_SLOTS:  shadow_hsync      = 32'(data[HSYNC_W-1:0]);
      CFG_LINE_SLOTS:   shadow_line_slots = 32'(data[LSLOTS_W-1:0]);
      CFG_VBLANK_LINES: shadow_vblank     = 32'(data[VBLANK_W-1:0]);
      CFG_VSYNC_LINES:  shadow_vsync      = 32'(data[VSYNC_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [PIX_ADDR_W-1:0] addr,
                         input logic [COLOR_W-1:0] color, input bit typed, input pix_t res);
    row_t r;
    r.req   = req;
    r.addr  = addr;
    r.color = color;
    r.typed = typed;
    r.res   = res;
    directed_rows.push_back(r);
  endtask

  task automatic send_random_item;
    int unsigned        pick;
    int unsigned        col;
    logic [PIX_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0] color;
    pick  = $urandom_range(0, 999);
    color = COLOR_W'($urandom_range(0, 7));
    addr  = PIX_ADDR_W'($urandom_range(0, 8191));
    if (pick < 680) begin
      send_item(REQ_TICK, addr, color, 1'b0, '0);
    end else if (pick < 950) begin
      if ($urandom_range(0, 3) < 2 && shadow_line < SCREEN_HEIGHT_DEF) begin
        col = (shadow_slot >= shadow_hsync) ? shadow_slot - shadow_hsync : 0;
        col += $urandom_range(0, 7);
        if (col >= SCREEN_WIDTH_DEF) col = $urandom_range(0, SCREEN_WIDTH_DEF - 1);
        addr = PIX_ADDR_W'(shadow_line * SCREEN_WIDTH_DEF + col);
      end
      send_item(REQ_WRITE, addr, color, 1'b0, '0);
    end else if (pick < 985) begin
      send_item(REQ_UNUSED, addr, color, 1'b0, '0);
    end else begin
      send_item(REQ_CLEAR, addr, color, 1'b0, '0);
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_small(input int unsigned lo,
                                                       input int unsigned hi);
    if ($urandom_range(0, 4) == 0) return CFG_DATA_W'($urandom_range(0, 255));
    return CFG_DATA_W'($urandom_range(lo, hi));
  endfunction

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = REQ_TICK;
    pixel_addr_i  = '0;
    pixel_color_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_HSYNC_SLOTS;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    err_count     = 0;

    for (int i = 0; i < STORE_SIZE; i++) shadow_store[i] = '0;
    shadow_slot       = 0;
    shadow_line       = 0;
    shadow_frames     = '0;
    shadow_hsync      = 32'(HSYNC_SLOTS_RST);
    shadow_line_slots = 32'(LINE_SLOTS_RST);
    shadow_vblank     = 32'(VBLANK_LINES_RST);
    shadow_vsync      = 32'(VSYNC_LINES_RST);

    phase_cfg[1] = '{8'd1, 8'd2, 8'd1, 8'd1};
    phase_cfg[2] = '{8'd3, 8'd0, 8'd0, 8'd1};
    phase_cfg[3] = '{8'd2, 8'd1, 8'd0, 8'd15};
    phase_cfg[4] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    for (int p = 5; p < NUM_PHASES - 1; p++)
      phase_cfg[p] = '{pick_small(0, 8), pick_small(2, 40), pick_small(0, 8),
                       pick_small(0, 15)};
    phase_cfg[NUM_PHASES-1] = '{8'd4, 8'd136, 8'd45, 8'd2};

    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    add_row(REQ_WRITE,  13'd0,    3'd7, 1'b0, '0);
    add_row(REQ_WRITE,  13'd1,    3'd5, 1'b0, '0);
    add_row(REQ_WRITE,  13'd7199, 3'd7, 1'b0, '0);
    add_row(REQ_WRITE,  13'd8191, 3'd3, 1'b0, '0);
    add_row(REQ_WRITE,  13'd7200, 3'd6, 1'b0, '0);
    add_row(REQ_UNUSED, 13'd2,    3'd7, 1'b0, '0);
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    add_row(REQ_TICK,   13'd8191, 3'd7, 1'b1, make_pix(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, '0));
    add_row(REQ_CLEAR,  13'd5,    3'd2, 1'b0, '0);
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, '0));
    add_row(REQ_WRITE,  13'd4,    3'd1, 1'b0, '0);
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b1, make_pix(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0));
    add_row(REQ_CLEAR,  13'd0,    3'd0, 1'b0, '0);
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b0, '0);
    add_row(REQ_WRITE,  13'd4096, 3'd4, 1'b0, '0);
    add_row(REQ_TICK,   13'd0,    3'd0, 1'b0, '0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].addr, directed_rows[i].color,
                directed_rows[i].typed, directed_rows[i].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        quiet = (p == NUM_PHASES - 1);
        cfg_write(CFG_HSYNC_SLOTS,  phase_cfg[p][0]);
        cfg_write(CFG_LINE_SLOTS,   phase_cfg[p][1]);
        cfg_write(CFG_VBLANK_LINES, phase_cfg[p][2]);
        cfg_write(CFG_VSYNC_LINES,  phase_cfg[p][3]);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == PHASE_ITEMS / 2) drain_results();
        if (!quiet && $urandom_range(0, 7) == 0) hold_input($urandom_range(1, 12));
        send_random_item();
      end
      send_item(REQ_TICK, '0, '0, 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
